// ----- rtl/largest_empty_square_scan_defines.svh -----
// Assertion macros shared by the largest empty square scan checkers.
`ifndef LARGEST_EMPTY_SQUARE_SCAN_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_SCAN_DEFINES_SVH

// Concurrent check, disabled while reset is asserted.
`define LESQ_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check, evaluated at every clock edge including reset.
`define LESQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lesq_pkg.sv -----
// Shared types and constants of the largest empty square scan.
`default_nettype none
package lesq_pkg;

  localparam int CHAR_W      = 8;
  localparam int SIDE_W      = 11;
  localparam int COORD_W     = 10;
  localparam int ROW_WIDTH_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_DATA_W  = 32;

  localparam logic [SIDE_W-1:0]      SIDE_MAX          = 11'h7FF;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET   = 11'd1;
  localparam logic [CHAR_W-1:0]      OBSTACLE_RESET    = 8'd111;

  typedef enum logic {
    CFG_ROW_WIDTH = 1'b0,
    CFG_OBSTACLE  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic last;
    logic eor;
    logic obstacle;
    logic border;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/lesq_line_buf.sv -----
// One-row line buffer of square sides with write-to-read forwarding.
`default_nettype none
module lesq_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire                        clk,
  input  wire                        rd_en,
  input  wire  [ADDR_W-1:0]          rd_addr,
  input  wire                        wr_en,
  input  wire  [ADDR_W-1:0]          wr_addr,
  input  wire  [lesq_pkg::SIDE_W-1:0] wr_data,
  output logic [lesq_pkg::SIDE_W-1:0] rd_data
);
  import lesq_pkg::*;

  logic [SIDE_W-1:0] mem [DEPTH];
  logic [SIDE_W-1:0] q_r;
  logic              fwd_r;
  logic [SIDE_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule
`default_nettype wire

// ----- rtl/lesq_tracker.sv -----
// Side computation stage, best square tracking and result register.
`default_nettype none
module lesq_tracker #(
  parameter int COL_W = 10,
  parameter int ROW_W = 10
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          acc,
  input  wire  lesq_pkg::cell_ctl_t    ctl_in,
  input  wire  [COL_W-1:0]             col_in,
  input  wire  [ROW_W-1:0]             row_in,
  input  wire  [lesq_pkg::SIDE_W-1:0]  up,
  output logic                         advance,
  output logic                         wr_en,
  output logic [COL_W-1:0]             wr_addr,
  output logic [lesq_pkg::SIDE_W-1:0]  wr_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [lesq_pkg::SIDE_W-1:0]  out_size,
  output logic [lesq_pkg::COORD_W-1:0] out_left,
  output logic [lesq_pkg::COORD_W-1:0] out_top
);
  import lesq_pkg::*;

  localparam int W1    = (COL_W + 1 > SIDE_W) ? COL_W + 1 : SIDE_W;
  localparam int CMP_W = (ROW_W + 1 > W1) ? ROW_W + 1 : W1;

  logic              s1_valid_r;
  cell_ctl_t         s1_ctl_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [SIDE_W-1:0] left_r;
  logic [SIDE_W-1:0] diag_r;
  logic [SIDE_W-1:0] best_side_r;
  logic [COORD_W-1:0] best_col_r;
  logic [COORD_W-1:0] best_row_r;
  logic              out_valid_r;
  logic [SIDE_W-1:0] out_size_r;
  logic [COORD_W-1:0] out_left_r;
  logic [COORD_W-1:0] out_top_r;

  logic               out_free;
  logic               s1_fire;
  logic [SIDE_W-1:0]  min3;
  logic [SIDE_W:0]    sum;
  logic [SIDE_W-1:0]  side;
  logic [CMP_W-1:0]   side_w;
  logic [CMP_W-1:0]   col1;
  logic [CMP_W-1:0]   row1;
  logic [CMP_W-1:0]   col_diff;
  logic [CMP_W-1:0]   row_diff;
  logic               better;
  logic [SIDE_W-1:0]  best_side_nxt;
  logic [COORD_W-1:0] best_col_nxt;
  logic [COORD_W-1:0] best_row_nxt;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_ctl_r.last || out_free);
  assign advance  = !s1_valid_r || s1_fire;

  always_comb begin
    min3 = up;
    if (left_r < min3) begin
      min3 = left_r;
    end
    if (diag_r < min3) begin
      min3 = diag_r;
    end
    sum = {1'b0, min3} + {{SIDE_W{1'b0}}, 1'b1};
    priority if (s1_ctl_r.obstacle) begin
      side = '0;
    end else if (s1_ctl_r.border) begin
      side = {{(SIDE_W-1){1'b0}}, 1'b1};
    end else if (sum[SIDE_W]) begin
      side = SIDE_MAX;
    end else begin
      side = sum[SIDE_W-1:0];
    end
    side_w   = CMP_W'(side);
    col1     = CMP_W'(s1_col_r) + CMP_W'(1);
    row1     = CMP_W'(s1_row_r) + CMP_W'(1);
    col_diff = col1 - side_w;
    row_diff = row1 - side_w;
    better   = (side > best_side_r) && (side_w <= col1) && (side_w <= row1);
    best_side_nxt = best_side_r;
    best_col_nxt  = best_col_r;
    best_row_nxt  = best_row_r;
    if (better) begin
      best_side_nxt = side;
      best_col_nxt  = col_diff[COORD_W-1:0];
      best_row_nxt  = row_diff[COORD_W-1:0];
    end
  end

  assign wr_en   = s1_fire;
  assign wr_addr = s1_col_r;
  assign wr_data = side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      left_r      <= '0;
      diag_r      <= '0;
      best_side_r <= '0;
      best_col_r  <= '0;
      best_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid_r <= acc;
      end
      if (s1_fire) begin
        if (s1_ctl_r.last) begin
          best_side_r <= '0;
          best_col_r  <= '0;
          best_row_r  <= '0;
          left_r      <= '0;
          diag_r      <= '0;
        end else begin
          best_side_r <= best_side_nxt;
          best_col_r  <= best_col_nxt;
          best_row_r  <= best_row_nxt;
          if (s1_ctl_r.eor) begin
            left_r <= '0;
            diag_r <= '0;
          end else begin
            left_r <= side;
            diag_r <= up;
          end
        end
      end
      if (s1_fire && s1_ctl_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && advance) begin
      s1_ctl_r <= ctl_in;
      s1_col_r <= col_in;
      s1_row_r <= row_in;
    end
    if (s1_fire && s1_ctl_r.last) begin
      out_size_r <= best_side_nxt;
      out_left_r <= best_col_nxt;
      out_top_r  <= best_row_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_size  = out_size_r;
  assign out_left  = out_left_r;
  assign out_top   = out_top_r;

endmodule
`default_nettype wire

// ----- rtl/largest_empty_square_scan.sv -----
// Largest empty square scan: top level with configuration and raster counters.
// Takes one grid cell per cycle in raster order; a cell's side is read from the
// line buffer when the cell is accepted, computed and written back as the cell
// leaves the stage; the last cell's result is then registered for output.
// Input is held off only while a finished result waits in the output register
// and the stage holds the next last cell. The line buffer has one entry per
// column (MAX_WIDTH entries) and needs no clearing pass after reset.
`default_nettype none
module largest_empty_square_scan #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wen,
  input  wire                              cfg_index,
  input  wire  [lesq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [7:0]                       in_tdata,   // cell_char
  input  wire                              in_tlast,   // last_cell
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [lesq_pkg::OUT_DATA_W-1:0]  out_tdata   // best_size, best_left, best_top
);
  import lesq_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = (COL_W + 2 > ROW_WIDTH_W) ? COL_W + 2 : ROW_WIDTH_W;

  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [CHAR_W-1:0]      obstacle_r;
  logic [COL_W-1:0]       col_r;
  logic [ROW_W-1:0]       row_r;

  logic              advance;
  logic              acc;
  logic [WW-1:0]     width_raw;
  logic [WW-1:0]     eff_width;
  logic [WW-1:0]     col_next;
  logic              eor;
  cell_ctl_t         ctl;
  logic [SIDE_W-1:0] up;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [SIDE_W-1:0] wr_data;
  logic [SIDE_W-1:0] res_size;
  logic [COORD_W-1:0] res_left;
  logic [COORD_W-1:0] res_top;

  assign in_tready = advance;
  assign acc       = in_tvalid && advance;

  always_comb begin
    width_raw = WW'(row_width_r);
    priority if (width_raw == '0) begin
      eff_width = WW'(1);
    end else if (width_raw > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = width_raw;
    end
    col_next     = WW'(col_r) + WW'(1);
    eor          = col_next >= eff_width;
    ctl.last     = in_tlast;
    ctl.eor      = eor;
    ctl.obstacle = in_tdata == obstacle_r;
    ctl.border   = (col_r == '0) || (row_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
      obstacle_r  <= OBSTACLE_RESET;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_ROW_WIDTH: row_width_r <= cfg_wdata[ROW_WIDTH_W-1:0];
          CFG_OBSTACLE:  obstacle_r  <= cfg_wdata[CHAR_W-1:0];
        endcase
      end
      if (acc) begin
        if (in_tlast) begin
          col_r <= '0;
          row_r <= '0;
        end else if (eor) begin
          col_r <= '0;
          row_r <= (row_r == ROW_W'(MAX_HEIGHT - 1)) ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_next[COL_W-1:0];
        end
      end
    end
  end

  lesq_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_r),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (up)
  );

  lesq_tracker #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .ctl_in    (ctl),
    .col_in    (col_r),
    .row_in    (row_r),
    .up        (up),
    .advance   (advance),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_size  (res_size),
    .out_left  (res_left),
    .out_top   (res_top)
  );

  assign out_tdata = {1'b0, res_top, res_left, res_size};

endmodule
`default_nettype wire

// ----- rtl/lesq_checker.sv -----
// Port-level checks of the largest empty square scan and their bind.
`default_nettype none
`include "largest_empty_square_scan_defines.svh"
module lesq_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata
);
  import lesq_pkg::*;

  `LESQ_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `LESQ_ASSERT_RST(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")
  `LESQ_ASSERT_RST(a_stall_only_on_result, clk, rst_n, !in_tready |-> out_tvalid, "input held off with no result pending")
  `LESQ_ASSERT_RST(a_empty_at_origin, clk, rst_n, (out_tvalid && (out_tdata[SIDE_W-1:0] == '0)) |-> (out_tdata[OUT_DATA_W-1:SIDE_W] == '0), "empty result has nonzero corner")

endmodule

bind largest_empty_square_scan lesq_checker u_lesq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
